// File: src/mips32_subset_executor_top_macros.svh
`ifndef MIPS32_SUBSET_EXECUTOR_TOP_MACROS_SVH
`define MIPS32_SUBSET_EXECUTOR_TOP_MACROS_SVH

// cond implies cons in the same cycle, checked on aclk outside reset
`define MSE_IMPLY(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (cons)) \
        else $error(msg);

// cond implies cons in the following cycle, checked on aclk outside reset
`define MSE_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (cons)) \
        else $error(msg);

`endif

// File: src/mse_pkg.sv
package mse_pkg;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2B;

    // function codes under OP_SPECIAL
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLTU = 6'h2B;

    localparam logic [4:0] REG_RA = 5'd31;

    // configuration register indexes
    localparam int         CFG_IDX_W      = 2;
    localparam logic [1:0] CFG_TEXT_START = 2'd0;
    localparam logic [1:0] CFG_TEXT_BYTES = 2'd1;
    localparam logic [1:0] CFG_DATA_BASE  = 2'd2;

    localparam logic [31:0] TEXT_START_RST = 32'h0040_0000;
    localparam logic [31:0] TEXT_BYTES_RST = 32'd4096;
    localparam logic [31:0] DATA_BASE_RST  = 32'h1000_0000;

    localparam int TDATA_W = 136;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_written;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        store_done;
        logic [31:0] store_address;
        logic [31:0] store_value;
        logic        halted;
    } mse_result_t;

endpackage

// File: src/mips32_subset_executor_top.sv
// MIPS32 subset executor: each s_ transaction carries one instruction word fetched at the
// current PC and produces exactly one m_ transaction with the next PC, the register write,
// the store and a halted flag (m_tuser). Register file and data memory are synchronous RAMs
// with registered reads; the instruction then runs through execute, two address stages
// (offset, then modulo by DATA_WORDS through a reciprocal multiply) and memory access.
// Sustained rate is one instruction per clock while m_tready is high; lw holds s_tready low
// until its word is back from the data memory and written to the register file. After
// reset a clearing pass zeroes every word of the data memory, during which no instruction
// is taken; configuration writes are taken at any time but are meant for an idle block.
// Once the PC leaves the text region every instruction is reported halted and ignored.
`include "mips32_subset_executor_top_macros.svh"

module mips32_subset_executor_top #(
    parameter int DATA_WORDS = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // instr_word
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // next_pc, reg_written, reg_index, reg_value, store_done, store_address,
    // store_value, one zero pad bit
    output logic [mse_pkg::TDATA_W-1:0]   m_tdata,
    output logic                          m_tuser,   // halted
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import mse_pkg::*;

    localparam int AW    = $clog2(DATA_WORDS);
    localparam int XW    = 30;
    localparam int RW    = XW + 1;
    localparam int PW    = XW + RW;
    localparam int SHIFT = XW + AW;
    localparam int QW    = XW - AW + 1;
    localparam logic [63:0] RECIP =
        ((64'd1 << SHIFT) + 64'(DATA_WORDS) - 64'd1) / 64'(DATA_WORDS);

    // configuration and architectural state
    logic [31:0] text_start_reg, text_bytes_reg, data_base_reg;
    logic [31:0] pc_reg;
    logic        stopped_reg;
    logic        clr_busy_reg;
    logic [AW-1:0] clr_idx_reg;

    // pipeline control
    logic en, s_fire, cfg_fire, ld_block;
    logic ex_valid_reg, a1_valid_reg, a2_valid_reg, mem_valid_reg, out_valid_reg;

    // register file
    logic [31:0] rf_mem [32];
    logic [31:0] rf_ok_reg;
    logic [31:0] ex_rf_a_reg, ex_rf_b_reg;
    logic        ex_rf_a_ok_reg, ex_rf_b_ok_reg;
    logic        ex_cap_a_hit_reg, ex_cap_b_hit_reg;
    logic [31:0] ex_cap_data_reg;
    logic        wport_en;
    logic [4:0]  wport_idx;
    logic [31:0] wport_data;
    logic        ex_rf_we, mem_rf_we;

    // execute stage
    logic [31:0] ex_instr_reg;
    logic [5:0]  ex_op, ex_fn;
    logic [4:0]  ex_rs, ex_rt, ex_rd, ex_sh;
    logic [31:0] ex_zimm, ex_simm, ex_a, ex_b, ex_pc4, ex_ea;
    logic        ex_halt, ex_wr, ex_ld, ex_st, ex_wr_fin, ex_ld_eff, ex_st_eff;
    logic [4:0]  ex_widx;
    logic [31:0] ex_wval, ex_npc;
    mse_result_t ex_res;

    // address stages
    mse_result_t a1_res_reg, a2_res_reg, mem_res_reg, out_res_reg;
    logic        a1_ld_reg, a1_st_reg, a2_ld_reg, a2_st_reg, mem_ld_reg;
    logic [31:0] a1_ea_reg, a1_off;
    logic [XW-1:0] a1_x, a2_x_reg, a2_qd, a2_r;
    logic [PW-1:0] a1_prod;
    logic [QW-1:0] a2_q_reg;
    logic [AW-1:0] a2_slot;

    // data memory
    logic [31:0]   dmem [DATA_WORDS];
    logic [31:0]   dmem_q_reg;
    logic          dmem_we, dmem_re;
    logic [AW-1:0] dmem_waddr;
    logic [31:0]   dmem_wdata;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign en        = !out_valid_reg || m_tready;
    // a load stays ahead of any later instruction until its register write
    assign ld_block  = (ex_valid_reg && (ex_instr_reg[31:26] == OP_LW))
                     || (a1_valid_reg && a1_ld_reg) || (a2_valid_reg && a2_ld_reg);
    assign s_tready  = en && !clr_busy_reg && !ld_block;
    assign s_fire    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_start_reg <= TEXT_START_RST;
            text_bytes_reg <= TEXT_BYTES_RST;
            data_base_reg  <= DATA_BASE_RST;
        end else if (cfg_fire) begin
            case (cfg_index)
                CFG_TEXT_START: text_start_reg <= cfg_data;
                CFG_TEXT_BYTES: text_bytes_reg <= cfg_data;
                CFG_DATA_BASE:  data_base_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= TEXT_START_RST;
            stopped_reg <= 1'b0;
        end else begin
            if (cfg_fire && (cfg_index == CFG_TEXT_START)) begin
                pc_reg <= cfg_data;
            end else if (ex_valid_reg && en && !ex_halt) begin
                pc_reg <= ex_npc;
            end
            if (ex_valid_reg && en && ex_halt) begin
                stopped_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end else if (clr_busy_reg) begin
            if (clr_idx_reg == AW'(DATA_WORDS - 1)) begin
                clr_busy_reg <= 1'b0;
            end else begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg  <= 1'b0;
            a1_valid_reg  <= 1'b0;
            a2_valid_reg  <= 1'b0;
            mem_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            ex_valid_reg  <= s_fire;
            a1_valid_reg  <= ex_valid_reg;
            a2_valid_reg  <= a1_valid_reg;
            mem_valid_reg <= a2_valid_reg;
            out_valid_reg <= mem_valid_reg;
        end
    end

    // register file write port: non-load results leave execute, load results leave memory
    assign ex_rf_we   = ex_valid_reg && en && ex_res.reg_written && !ex_ld_eff;
    assign mem_rf_we  = mem_valid_reg && en && mem_ld_reg && mem_res_reg.reg_written;
    assign wport_en   = ex_rf_we || mem_rf_we;
    assign wport_idx  = mem_rf_we ? mem_res_reg.reg_index : ex_res.reg_index;
    assign wport_data = mem_rf_we ? dmem_q_reg : ex_res.reg_value;

    always_ff @(posedge aclk) begin
        if (wport_en) begin
            rf_mem[wport_idx] <= wport_data;
        end
        if (s_fire) begin
            ex_rf_a_reg <= rf_mem[s_tdata[25:21]];
            ex_rf_b_reg <= rf_mem[s_tdata[20:16]];
        end
    end

    // entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_ok_reg <= '0;
        end else if (wport_en) begin
            rf_ok_reg[wport_idx] <= 1'b1;
        end
    end

    // the write landing on the read edge is missed by the ram, so catch it here
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            ex_instr_reg     <= s_tdata;
            ex_rf_a_ok_reg   <= rf_ok_reg[s_tdata[25:21]];
            ex_rf_b_ok_reg   <= rf_ok_reg[s_tdata[20:16]];
            ex_cap_a_hit_reg <= wport_en && (wport_idx == s_tdata[25:21]);
            ex_cap_b_hit_reg <= wport_en && (wport_idx == s_tdata[20:16]);
            ex_cap_data_reg  <= wport_data;
        end
    end

    always_comb begin
        ex_op   = ex_instr_reg[31:26];
        ex_rs   = ex_instr_reg[25:21];
        ex_rt   = ex_instr_reg[20:16];
        ex_rd   = ex_instr_reg[15:11];
        ex_sh   = ex_instr_reg[10:6];
        ex_fn   = ex_instr_reg[5:0];
        ex_zimm = {16'h0000, ex_instr_reg[15:0]};
        ex_simm = {{16{ex_instr_reg[15]}}, ex_instr_reg[15:0]};
        ex_a    = ex_cap_a_hit_reg ? ex_cap_data_reg : (ex_rf_a_ok_reg ? ex_rf_a_reg : '0);
        ex_b    = ex_cap_b_hit_reg ? ex_cap_data_reg : (ex_rf_b_ok_reg ? ex_rf_b_reg : '0);
        ex_pc4  = pc_reg + 32'd4;
        ex_ea   = ex_a + ex_simm;
        ex_halt = stopped_reg || ((pc_reg - text_start_reg) >= text_bytes_reg);

        ex_wr   = 1'b0;
        ex_ld   = 1'b0;
        ex_st   = 1'b0;
        ex_widx = ex_rt;
        ex_wval = '0;
        ex_npc  = ex_pc4;

        unique case (ex_op)
            OP_SPECIAL: begin
                ex_wr   = 1'b1;
                ex_widx = ex_rd;
                unique case (ex_fn)
                    FN_ADDU: ex_wval = ex_a + ex_b;
                    FN_SUBU: ex_wval = ex_a - ex_b;
                    FN_AND:  ex_wval = ex_a & ex_b;
                    FN_OR:   ex_wval = ex_a | ex_b;
                    FN_NOR:  ex_wval = ~(ex_a | ex_b);
                    FN_SLTU: ex_wval = 32'(ex_a < ex_b);
                    FN_SLL:  ex_wval = ex_b << ex_sh;
                    FN_SRL:  ex_wval = ex_b >> ex_sh;
                    FN_JR: begin
                        ex_wr  = 1'b0;
                        ex_npc = ex_a;
                    end
                    default: ex_wr = 1'b0;
                endcase
            end
            OP_J: ex_npc = {ex_pc4[31:28], ex_instr_reg[25:0], 2'b00};
            OP_JAL: begin
                ex_npc  = {ex_pc4[31:28], ex_instr_reg[25:0], 2'b00};
                ex_wr   = 1'b1;
                ex_widx = REG_RA;
                ex_wval = ex_pc4;
            end
            OP_ADDIU: begin
                ex_wr   = 1'b1;
                ex_wval = ex_ea;
            end
            OP_ANDI: begin
                ex_wr   = 1'b1;
                ex_wval = ex_a & ex_zimm;
            end
            OP_ORI: begin
                ex_wr   = 1'b1;
                ex_wval = ex_a | ex_zimm;
            end
            OP_LUI: begin
                ex_wr   = 1'b1;
                ex_wval = {ex_instr_reg[15:0], 16'h0000};
            end
            OP_SLTIU: begin
                ex_wr   = 1'b1;
                ex_wval = 32'(ex_a < ex_simm);
            end
            OP_LW: begin
                ex_wr = 1'b1;
                ex_ld = 1'b1;
            end
            OP_SW: ex_st = 1'b1;
            OP_BEQ: begin
                if (ex_a == ex_b) begin
                    ex_npc = ex_pc4 + {ex_simm[29:0], 2'b00};
                end
            end
            OP_BNE: begin
                if (ex_a != ex_b) begin
                    ex_npc = ex_pc4 + {ex_simm[29:0], 2'b00};
                end
            end
            default: ;
        endcase

        ex_wr_fin = ex_wr && (ex_widx != '0) && !ex_halt;
        ex_ld_eff = ex_ld && !ex_halt;
        ex_st_eff = ex_st && !ex_halt;

        ex_res.next_pc       = ex_halt ? pc_reg : ex_npc;
        ex_res.reg_written   = ex_wr_fin;
        ex_res.reg_index     = ex_wr_fin ? ex_widx : '0;
        ex_res.reg_value     = (ex_wr_fin && !ex_ld) ? ex_wval : '0;
        ex_res.store_done    = ex_st_eff;
        ex_res.store_address = ex_st_eff ? ex_ea : '0;
        ex_res.store_value   = ex_st_eff ? ex_b : '0;
        ex_res.halted        = ex_halt;
    end

    // word slot = ((ea - data_base) >> 2) mod DATA_WORDS via reciprocal multiply
    assign a1_off  = a1_ea_reg - data_base_reg;
    assign a1_x    = a1_off[31:2];
    assign a1_prod = PW'(a1_x) * PW'(RECIP[RW-1:0]);
    assign a2_qd   = XW'(a2_q_reg) * XW'(DATA_WORDS);
    assign a2_r    = a2_x_reg - a2_qd;
    assign a2_slot = a2_r[AW-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_res_reg  <= ex_res;
            a1_ld_reg   <= ex_ld_eff;
            a1_st_reg   <= ex_st_eff;
            a1_ea_reg   <= ex_ea;
            a2_res_reg  <= a1_res_reg;
            a2_ld_reg   <= a1_ld_reg;
            a2_st_reg   <= a1_st_reg;
            a2_x_reg    <= a1_x;
            a2_q_reg    <= a1_prod[SHIFT +: QW];
            mem_res_reg <= a2_res_reg;
            mem_ld_reg  <= a2_ld_reg;
            out_res_reg <= mem_res_reg;
            if (mem_ld_reg && mem_res_reg.reg_written) begin
                out_res_reg.reg_value <= dmem_q_reg;
            end
        end
    end

    assign dmem_we    = clr_busy_reg || (a2_valid_reg && en && a2_st_reg);
    assign dmem_waddr = clr_busy_reg ? clr_idx_reg : a2_slot;
    assign dmem_wdata = clr_busy_reg ? '0 : a2_res_reg.store_value;
    assign dmem_re    = a2_valid_reg && en && a2_ld_reg;

    always_ff @(posedge aclk) begin
        if (dmem_we) begin
            dmem[dmem_waddr] <= dmem_wdata;
        end
        if (dmem_re) begin
            dmem_q_reg <= dmem[a2_slot];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.halted;
    assign m_tdata  = {1'b0,
                       out_res_reg.store_value,
                       out_res_reg.store_address,
                       out_res_reg.store_done,
                       out_res_reg.reg_value,
                       out_res_reg.reg_index,
                       out_res_reg.reg_written,
                       out_res_reg.next_pc};

    `MSE_IMPLY(a_no_accept_clearing, clr_busy_reg, !s_tready, "instruction taken during memory clear")
    `MSE_IMPLY(a_single_rf_writer, ex_rf_we, !mem_rf_we, "two register file writes in one cycle")
    `MSE_IMPLY(a_r0_untouched, wport_en, wport_idx != '0, "register zero written")
    `MSE_IMPLY(a_load_blocks_input, a2_valid_reg && a2_ld_reg, !s_tready, "instruction taken behind a load")
    `MSE_NEXT(a_stop_sticky, stopped_reg, stopped_reg, "halt flag cleared")

endmodule
